// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_DEL  = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic enq;       // insert the latched entry
        logic deq;       // drop the front entry
        logic del_step;  // remove the first matching entry
        logic load;      // load the result register
    } spq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  match_any;
        logic  out_free;
    } spq_stat_t;

endpackage

// File: hdl/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.kind)
                    KIND_ENQ: begin
                        if (stat.out_free) begin
                            cmd.enq    = !stat.full;
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_DEQ: begin
                        if (stat.out_free) begin
                            cmd.deq    = !stat.empty;
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_DEL: begin
                        // one matching entry removed per cycle
                        if (stat.match_any) begin
                            cmd.del_step = 1'b1;
                        end else if (stat.out_free) begin
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        if (stat.out_free) begin
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_cmd_t           cmd,
    output spq_stat_t          stat,
    input  kind_t              in_kind,
    input  logic [VALUE_W-1:0] in_value,
    input  logic [PRIO_W-1:0]  in_prio,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  out_status,
    output logic [VALUE_W-1:0] out_value,
    output logic [PRIO_W-1:0]  out_prio,
    output logic [COUNT_W-1:0] out_removed,
    output logic [COUNT_W-1:0] out_count
);

    localparam int CW = $clog2(DEPTH + 1);

    // Latched item
    kind_t              kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [PRIO_W-1:0]  prio_reg;

    // Sorted cell chain, front at cell 0
    logic [VALUE_W-1:0] cell_val_reg  [DEPTH];
    logic [VALUE_W-1:0] cell_val_next [DEPTH];
    logic [PRIO_W-1:0]  cell_pri_reg  [DEPTH];
    logic [PRIO_W-1:0]  cell_pri_next [DEPTH];
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CW-1:0]      rem_reg;

    // Result register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [PRIO_W-1:0]  out_prio_reg;
    logic [COUNT_W-1:0] out_removed_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Per-cell compares
    logic [DEPTH-1:0] le;      // held and priority <= new priority
    logic [DEPTH-1:0] match;   // held and value equals delete value
    logic [DEPTH-1:0] pmatch;  // some match at or below this cell

    logic full, empty;

    assign full  = (occ_reg == CW'(DEPTH));
    assign empty = (occ_reg == '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cmp
            assign le[g]    = (CW'(g) < occ_reg) && (cell_pri_reg[g] <= prio_reg);
            assign match[g] = (CW'(g) < occ_reg) && (cell_val_reg[g] == value_reg);
            if (g == 0) begin : g_first
                assign pmatch[g] = match[g];
            end else begin : g_rest
                assign pmatch[g] = pmatch[g-1] | match[g];
            end
        end
    endgenerate

    // Cell next values
    always_comb begin
        cell_val_next = cell_val_reg;
        cell_pri_next = cell_pri_reg;
        occ_next      = occ_reg;
        for (int i = 0; i < DEPTH; i++) begin
            if (cmd.enq) begin
                // keep lower-or-equal entries, insert after them, shift the rest up
                if (!le[i]) begin
                    if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
                        cell_val_next[i] = value_reg;
                        cell_pri_next[i] = prio_reg;
                    end else begin
                        cell_val_next[i] = cell_val_reg[(i == 0) ? 0 : i-1];
                        cell_pri_next[i] = cell_pri_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (cmd.deq || (cmd.del_step && pmatch[i])) begin
                // close the gap from above
                if (i < DEPTH - 1) begin
                    cell_val_next[i] = cell_val_reg[(i < DEPTH - 1) ? i+1 : i];
                    cell_pri_next[i] = cell_pri_reg[(i < DEPTH - 1) ? i+1 : i];
                end
            end
        end
        if (cmd.enq) begin
            occ_next = occ_reg + 1'b1;
        end else if (cmd.deq || cmd.del_step) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    // Cell storage and latched item
    always_ff @(posedge aclk) begin
        cell_val_reg <= cell_val_next;
        cell_pri_reg <= cell_pri_next;
        if (cmd.capture) begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
            prio_reg  <= in_prio;
        end
    end

    // Occupancy and removal count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            rem_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            if (cmd.capture) begin
                rem_reg <= '0;
            end else if (cmd.del_step) begin
                rem_reg <= rem_reg + 1'b1;
            end
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg  <= STAT_OK;
            out_value_reg   <= '0;
            out_prio_reg    <= '0;
            out_removed_reg <= '0;
            out_count_reg   <= COUNT_W'(occ_next);
            case (kind_reg)
                KIND_ENQ: begin
                    if (full) begin
                        out_status_reg <= STAT_FULL;
                    end
                end
                KIND_DEQ: begin
                    if (empty) begin
                        out_status_reg <= STAT_EMPTY;
                    end else begin
                        out_value_reg   <= cell_val_reg[0];
                        out_prio_reg    <= cell_pri_reg[0];
                        out_removed_reg <= COUNT_W'(1);
                    end
                end
                KIND_DEL: begin
                    out_removed_reg <= COUNT_W'(rem_reg);
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.kind      = kind_reg;
    assign stat.full      = full;
    assign stat.empty     = empty;
    assign stat.match_any = pmatch[DEPTH-1];
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_value   = out_value_reg;
    assign out_prio    = out_prio_reg;
    assign out_removed = out_removed_reg;
    assign out_count   = out_count_reg;

endmodule

// File: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue of up to DEPTH entries (value, priority); lowest
// priority number leaves first, equal priorities leave in arrival order.
// Input: s_tuser carries the operation (enqueue, dequeue front, delete all
// entries with a value); s_tdata carries the value and priority.
// Output: one result transfer per input transfer. m_tuser is the status
// (ok, full and dropped, empty); m_tdata carries the dequeued entry, the
// number of entries removed and the number held afterwards.
// m_tvalid rises once the item has been taken and then executed, which waits
// for a free result register; a delete also stays in execution while any entry
// matches, since the cell chain removes one entry per cycle.
// An item is taken in the idle state and executed in the execute state; no new
// item is taken until the current one has finished execution.
// A new item is accepted while the previous result still waits on
// m_tready; the item then holds in execution until the result register
// frees up, and no further input is taken meanwhile.
// Reset (aresetn low, synchronous) empties the queue and drops any
// pending result.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [63:0] m_tdata    // [31:0] front_value, [47:32] front_priority,
                                   // [52:48] removed_count, [57:53] entry_count
);

    spq_cmd_t           cmd;
    spq_stat_t          stat;
    logic [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]  out_prio;
    logic [COUNT_W-1:0] out_removed;
    logic [COUNT_W-1:0] out_count;

    // Sequencer
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Cell chain and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (kind_t'(s_tuser)),
        .in_value    (s_tdata[31:0]),
        .in_prio     (s_tdata[47:32]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_value   (out_value),
        .out_prio    (out_prio),
        .out_removed (out_removed),
        .out_count   (out_count)
    );

    // Result packing
    assign m_tdata = {6'd0, out_count, out_removed, out_prio, out_value};

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 40;

    // Sorted-queue predictor and expected-result store
    class pq_scoreboard;
        typedef struct packed {
            logic [31:0] value;
            logic [15:0] prio;
        } entry_t;

        typedef struct packed {
            logic [1:0]  status;
            logic [31:0] front_value;
            logic [15:0] front_prio;
            logic [4:0]  removed;
            logic [4:0]  count;
        } outcome_t;

        int       capacity;
        entry_t   held[$];
        outcome_t expected[$];
        int       mismatches;

        function new(int capacity_i);
            capacity   = capacity_i;
            mismatches = 0;
        endfunction

        // Apply one accepted operation to the predicted queue
        function void note_item(kind_t op, logic [31:0] v, logic [15:0] p);
            outcome_t r;
            entry_t   e;
            entry_t   kept[$];
            int       pos;
            r = '0;
            r.status = STAT_OK;
            case (op)
                KIND_ENQ: begin
                    if (held.size() >= capacity) begin
                        r.status = STAT_FULL;
                    end else begin
                        // goes behind every entry of equal or lower number
                        pos = 0;
                        while (pos < held.size() && held[pos].prio <= p) pos++;
                        e.value = v;
                        e.prio  = p;
                        held.insert(pos, e);
                    end
                end
                KIND_DEQ: begin
                    if (held.size() == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        e = held.pop_front();
                        r.front_value = e.value;
                        r.front_prio  = e.prio;
                        r.removed     = 5'd1;
                    end
                end
                KIND_DEL: begin
                    foreach (held[i]) if (held[i].value != v) kept.push_back(held[i]);
                    r.removed = 5'(held.size() - kept.size());
                    held = kept;
                end
                default: ;
            endcase
            r.count = 5'(held.size());
            expected.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [1:0] st, logic [63:0] data);
            outcome_t got, want;
            got.status      = st;
            got.front_value = data[31:0];
            got.front_prio  = data[47:32];
            got.removed     = data[52:48];
            got.count       = data[57:53];
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: status %0d data %h",
                             $time, st, data);
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status || got.front_value !== want.front_value ||
                got.front_prio !== want.front_prio || got.removed !== want.removed ||
                got.count !== want.count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch, expected st %0d val %h pri %0d rem %0d cnt %0d",
                             $time, want.status, want.front_value, want.front_prio,
                             want.removed, want.count);
                    $display("%0t:           actual   st %0d val %h pri %0d rem %0d cnt %0d",
                             $time, got.status, got.front_value, got.front_prio,
                             got.removed, got.count);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [63:0] m_tdata;

    pq_scoreboard sb;

    int send_gap_pct;
    int stall_pct;
    int pool_n;
    int idle_cycles;

    logic [31:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                     32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_002A,
                                     32'h5555_5555, 32'hAAAA_AAAA};

    sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        sb           = new(QDEPTH);
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = '0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        pool_n       = 8;
        idle_cycles  = 0;
    end

    // Transfer monitors: feed the predictor and check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(kind_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side backpressure in bursts
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Drive one operation and wait for its transfer
    task automatic send_op(kind_t op, logic [31:0] v, logic [15:0] p);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {p, v};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, pool_n - 1)];
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hFFFF - 16'($urandom_range(0, 1));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Delete targets mostly hit something that is held
    function automatic logic [31:0] pick_victim();
        if (sb.held.size() > 0 && $urandom_range(0, 9) < 6)
            return sb.held[$urandom_range(0, sb.held.size() - 1)].value;
        return pick_value();
    endfunction

    initial begin
        int sent;
        int phase_len;
        int mode;
        int enq_pct;
        int deq_pct;
        int del_pct;
        int roll;
        int j;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty cases, no-op, extremes, ties and delete
        send_op(KIND_DEQ, 32'h0, 16'h0);
        send_op(KIND_DEL, 32'h0, 16'h0);
        send_op(KIND_NOP, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_ENQ, 32'h8000_0000, 16'hFFFF);
        send_op(KIND_ENQ, 32'h7FFF_FFFF, 16'h0000);
        send_op(KIND_ENQ, 32'h0000_0005, 16'd100);
        send_op(KIND_ENQ, 32'h0000_0006, 16'd100);
        send_op(KIND_ENQ, 32'h0000_0005, 16'd100);
        send_op(KIND_ENQ, 32'hFFFF_FFFF, 16'h0000);   // ties with the head
        send_op(KIND_DEL, 32'h0000_0005, 16'hFFFF);
        send_op(KIND_DEL, 32'h0000_1234, 16'h0);
        send_op(KIND_NOP, 32'h0, 16'h0);
        repeat (5) send_op(KIND_DEQ, 32'h0, 16'h0);  // last one hits empty
        send_op(KIND_DEL, 32'hFFFF_FFFF, 16'h0);

        // Random phases: fill, drain and mixed traffic
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 150);
            mode      = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0: pool_n = 1;
                1: pool_n = 3;
                default: pool_n = 8;
            endcase
            case (mode)
                0: begin enq_pct = 75; deq_pct = 15; del_pct = 7; end
                1: begin enq_pct = 20; deq_pct = 65; del_pct = 12; end
                default: begin enq_pct = 45; deq_pct = 35; del_pct = 17; end
            endcase
            case ($urandom_range(0, 2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 10;
                default: send_gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 5;
                default: stall_pct = 20;
            endcase
            for (j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
                // no idling over the tail of the run
                if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                roll = $urandom_range(0, 99);
                if (roll < enq_pct)
                    send_op(KIND_ENQ, pick_value(), pick_prio());
                else if (roll < enq_pct + deq_pct)
                    send_op(KIND_DEQ, $urandom, 16'($urandom));
                else if (roll < enq_pct + deq_pct + del_pct)
                    send_op(KIND_DEL, pick_victim(), 16'($urandom));
                else
                    send_op(KIND_NOP, $urandom, 16'($urandom));
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
dv/testbench.sv
